// ===== rtl/hrs_pkg.sv =====
// ----------------------------------------------------------------------------
// hrs_pkg: shared types and constants for the HTTP response splitter
// Command codes, queue entry type, limits and derived counter widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrs_pkg;

  localparam int HEADER_LIMIT = 128;
  localparam int BODY_LIMIT   = 128;
  localparam int QUEUE_DEPTH  = 4;

  localparam int HDR_CNT_W = $clog2(HEADER_LIMIT + 1);
  localparam int BODY_CNT_W = $clog2(BODY_LIMIT + 1);
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam int CODE_W   = 10;
  localparam int OUT_W    = 22;
  localparam int OUT_TD_W = 24;
  localparam int IN_TD_W  = 8;
  localparam int IN_TU_W  = 2;

  // operation codes on the input channel
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_CLOSE,
    CMD_START,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } entry_t;

  // expected character of the CR LF CR LF separator at a given match position
  function automatic logic [7:0] sep_char(input logic [1:0] pos);
    return pos[0] ? CH_LF : CH_CR;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hrs_front.sv =====
// ----------------------------------------------------------------------------
// hrs_front: input stage of the HTTP response splitter
// Takes input transfers, decodes the operation and hands entries to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrs_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_valid_i,
  output logic                          s_ready_o,
  input  wire  [hrs_pkg::IN_TU_W-1:0]   s_op_i,
  input  wire  [7:0]                    s_data_i,
  output logic                          push_o,
  output hrs_pkg::entry_t               push_entry_o,
  input  wire                           q_full_i
);

  logic            valid_q, valid_d;
  hrs_pkg::entry_t entry_q, entry_d;
  hrs_pkg::cmd_e   cmd;

  always_comb begin
    unique case (s_op_i)
      hrs_pkg::OP_DATA:  cmd = hrs_pkg::CMD_DATA;
      hrs_pkg::OP_CLOSE: cmd = hrs_pkg::CMD_CLOSE;
      hrs_pkg::OP_START: cmd = hrs_pkg::CMD_START;
      default:           cmd = hrs_pkg::CMD_NOP;
    endcase
  end

  assign push_o       = valid_q && !q_full_i;
  assign s_ready_o    = !valid_q || !q_full_i;
  assign push_entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
      entry_d = '{cmd: cmd, data: s_data_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ===== rtl/hrs_queue.sv =====
// ----------------------------------------------------------------------------
// hrs_queue: short queue between front and back of the response splitter
// Register-based FIFO of decoded entries, push and pop in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrs_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  hrs_pkg::entry_t  push_entry_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             empty_o,
  output hrs_pkg::entry_t  head_o
);

  hrs_pkg::entry_t                  mem_q [hrs_pkg::QUEUE_DEPTH];
  logic [hrs_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [hrs_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [hrs_pkg::QCNT_W-1:0]       count_q, count_d;

  assign full_o  = (count_q == hrs_pkg::QCNT_W'(hrs_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hrs_pkg::QPTR_W'(hrs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == hrs_pkg::QPTR_W'(hrs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hrs_back.sv =====
// ----------------------------------------------------------------------------
// hrs_back: parser and output stage of the response splitter
// Runs the header, status line and body state per entry, registers results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrs_back (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             q_empty_i,
  input  hrs_pkg::entry_t                 q_head_i,
  output logic                            pop_o,
  output logic                            m_valid_o,
  input  wire                             m_ready_i,
  output logic [hrs_pkg::OUT_TD_W-1:0]    m_data_o
);

  logic [hrs_pkg::HDR_CNT_W-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [1:0]                     sep_q, sep_d;
  logic                           in_body_q, in_body_d;
  logic [hrs_pkg::BODY_CNT_W-1:0] body_cnt_q, body_cnt_d;
  logic                           space_q, space_d;
  logic [1:0]                     digits_q, digits_d;
  logic [hrs_pkg::CODE_W-1:0]     code_q, code_d;
  logic                           bad_q, bad_d;
  logic                           prev_cr_q, prev_cr_d;
  logic                           settled_q, settled_d;
  logic                           closed_q, closed_d;

  logic                           out_valid_q;
  logic [hrs_pkg::OUT_W-1:0]      out_data_q, out_data_d;

  logic [7:0]                     b;
  logic                           keep;
  logic                           ok;
  logic [hrs_pkg::HDR_CNT_W-1:0]  hdr_inc;

  assign b     = q_head_i.data;
  assign pop_o = !q_empty_i && (!out_valid_q || m_ready_i);

  assign hdr_inc = hdr_cnt_q + 1'b1;

  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    sep_d      = sep_q;
    in_body_d  = in_body_q;
    body_cnt_d = body_cnt_q;
    space_d    = space_q;
    digits_d   = digits_q;
    code_d     = code_q;
    bad_d      = bad_q;
    prev_cr_d  = prev_cr_q;
    settled_d  = settled_q;
    closed_d   = closed_q;
    keep       = 1'b0;

    unique case (q_head_i.cmd)
      hrs_pkg::CMD_START: begin
        hdr_cnt_d  = '0;
        sep_d      = '0;
        in_body_d  = 1'b0;
        body_cnt_d = '0;
        space_d    = 1'b0;
        digits_d   = '0;
        code_d     = '0;
        bad_d      = 1'b0;
        prev_cr_d  = 1'b0;
        settled_d  = 1'b0;
        closed_d   = 1'b0;
      end
      hrs_pkg::CMD_CLOSE: begin
        if (!closed_q) begin
          closed_d  = 1'b1;
          settled_d = 1'b1;
        end
      end
      hrs_pkg::CMD_DATA: begin
        if (!closed_q) begin
          if (in_body_q) begin
            if (body_cnt_q < hrs_pkg::BODY_CNT_W'(hrs_pkg::BODY_LIMIT)) begin
              body_cnt_d = body_cnt_q + 1'b1;
              keep       = 1'b1;
            end
          end else begin
            // status line parse on counted header bytes
            if (hdr_cnt_q < hrs_pkg::HDR_CNT_W'(hrs_pkg::HEADER_LIMIT)) begin
              hdr_cnt_d = hdr_inc;
              if (!settled_q) begin
                if (prev_cr_q && b == hrs_pkg::CH_LF) begin
                  settled_d = 1'b1;
                end else begin
                  if (!space_q) begin
                    if (b == hrs_pkg::CH_SPACE) begin
                      space_d = 1'b1;
                    end
                  end else if (digits_q != 2'd3) begin
                    if (b >= hrs_pkg::CH_ZERO && b <= hrs_pkg::CH_NINE) begin
                      code_d = {code_q[6:0], 3'b000} + {code_q[8:0], 1'b0}
                             + hrs_pkg::CODE_W'(b - hrs_pkg::CH_ZERO);
                    end else begin
                      bad_d = 1'b1;
                    end
                    digits_d = digits_q + 1'b1;
                  end
                  prev_cr_d = (b == hrs_pkg::CH_CR);
                  // header limit filled with no line end
                  if (hdr_inc >= hrs_pkg::HDR_CNT_W'(hrs_pkg::HEADER_LIMIT)) begin
                    bad_d     = 1'b1;
                    settled_d = 1'b1;
                  end
                end
              end
            end
            // separator matcher sees every header byte
            if (b == hrs_pkg::sep_char(sep_q)) begin
              sep_d = sep_q + 1'b1;
              if (sep_q == 2'd3) begin
                in_body_d = 1'b1;
              end
            end else begin
              sep_d = (b == hrs_pkg::CH_CR) ? 2'd1 : 2'd0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    ok = settled_d && space_d && (digits_d == 2'd3) && !bad_d;
    out_data_d = {closed_d,
                  ok ? code_d : {hrs_pkg::CODE_W{1'b0}},
                  ok,
                  settled_d,
                  keep,
                  keep ? b : 8'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q   <= '0;
      sep_q       <= '0;
      in_body_q   <= 1'b0;
      body_cnt_q  <= '0;
      space_q     <= 1'b0;
      digits_q    <= '0;
      code_q      <= '0;
      bad_q       <= 1'b0;
      prev_cr_q   <= 1'b0;
      settled_q   <= 1'b0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        hdr_cnt_q  <= hdr_cnt_d;
        sep_q      <= sep_d;
        in_body_q  <= in_body_d;
        body_cnt_q <= body_cnt_d;
        space_q    <= space_d;
        digits_q   <= digits_d;
        code_q     <= code_d;
        bad_q      <= bad_d;
        prev_cr_q  <= prev_cr_d;
        settled_q  <= settled_d;
        closed_q   <= closed_d;
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {{(hrs_pkg::OUT_TD_W - hrs_pkg::OUT_W){1'b0}}, out_data_q};

endmodule

`default_nettype wire

// ===== rtl/http_response_splitter.sv =====
// ----------------------------------------------------------------------------
// http_response_splitter: HTTP response status parser and body splitter
// Splits a byte stream into status result, headers and limited body.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one transfer per response byte or control event:
//   s_axis_tuser_i holds the operation (data byte, peer close, start new
//   response), s_axis_tdata_i the byte. Every input transfer yields exactly
//   one output transfer on the m_axis side with the body byte, its keep
//   flag, the status line result and the finished flag.
//   An accepted item passes through the front register, then a queue entry,
//   then the result register, before it shows on m_axis_tvalid_o.
//   Throughput: one item per cycle while m_axis_tready_i stays high; the
//   parser updates its whole state in the cycle an entry leaves the queue.
//   The four-entry queue decouples intake from the result register: when the
//   receiver stalls, the result holds, the queue fills, and s_axis_tready_o
//   drops once both the queue and the front register are occupied.
//   Reset clears all parse state and empties the queue and output register;
//   a start-new-response transfer clears the parse state in-band.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_response_splitter (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire  [hrs_pkg::IN_TD_W-1:0]     s_axis_tdata_i,  // [7:0] data_byte
  input  wire  [hrs_pkg::IN_TU_W-1:0]     s_axis_tuser_i,  // [1:0] operation
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  // [7:0] body_byte, [8] body_keep, [9] status_settled, [10] status_ok,
  // [20:11] status_code, [21] finished, [23:22] zero
  output logic [hrs_pkg::OUT_TD_W-1:0]    m_axis_tdata_o
);

  logic            push;
  hrs_pkg::entry_t push_entry;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  hrs_pkg::entry_t q_head;

  hrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_op_i       (s_axis_tuser_i),
    .s_data_i     (s_axis_tdata_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .q_full_i     (q_full)
  );

  hrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  hrs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ===== rtl/hrs_checker.sv =====
// ----------------------------------------------------------------------------
// hrs_checker: port-level checks for the HTTP response splitter
// Watches the output stream for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrs_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          m_axis_tvalid_o,
  input wire                          m_axis_tready_i,
  input wire [hrs_pkg::OUT_TD_W-1:0]  m_axis_tdata_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  a_body_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[8] |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("body byte not zero without keep");

  a_ok_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[10] |-> m_axis_tdata_o[9])
    else $error("status ok before settled");

  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[10] |-> m_axis_tdata_o[20:11] == 10'd0)
    else $error("status code set without ok");

  a_fin_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[21] |-> m_axis_tdata_o[9] && !m_axis_tdata_o[8])
    else $error("finished without settled status or with body byte");

endmodule

bind http_response_splitter hrs_checker u_hrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ===== tb/sv/http_response_splitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_splitter_tb: self-checking bench for the HTTP response splitter
// A short directed table walks the status parser, separator and close
// handling; random responses with random content follow. Every output
// transfer is checked against a local parser model kept in step with the
// input transfers, under bursty input and a patterned output stall.
// ----------------------------------------------------------------------------

module http_response_splitter_tb;

  import hrs_pkg::*;

  // bit order matches m_axis_tdata_o[21:0]
  typedef struct packed {
    logic              finished;
    logic [CODE_W-1:0] code;
    logic              ok;
    logic              settled;
    logic              keep;
    logic [7:0]        body;
  } result_t;

  typedef struct {
    cmd_e       op;
    logic [7:0] b;
    bit         fixed;
    result_t    res;
  } stim_row_t;

  localparam int NUM_ITEMS = 650;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [IN_TD_W-1:0]  s_data = '0;  // [7:0] data_byte
  logic [IN_TU_W-1:0]  s_user = '0;  // [1:0] operation
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OUT_TD_W-1:0] m_data;       // [7:0] body_byte, [8] body_keep,
                                     // [9] status_settled, [10] status_ok,
                                     // [20:11] status_code, [21] finished

  // parser model state
  logic [7:0]        hdr_cnt;
  logic [2:0]        sep_pos;
  logic              body_mode;
  logic [7:0]        body_cnt;
  logic              sp_seen;
  logic [1:0]        dig_cnt;
  logic [CODE_W-1:0] code_acc;
  logic              code_err;
  logic              last_cr;
  logic              line_done;
  logic              closed;

  result_t   expected_q[$];
  stim_row_t dir_rows[$];

  int fails = 0;
  int n_items = 0;
  int n_results = 0;
  int n_kept = 0;
  int n_code_ok = 0;
  int n_code_err = 0;
  int n_hdr_full = 0;
  int burst_left = 0;

  always #5 clk_i = ~clk_i;

  http_response_splitter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  function automatic void clear_parse();
    hdr_cnt   = '0;
    sep_pos   = '0;
    body_mode = 1'b0;
    body_cnt  = '0;
    sp_seen   = 1'b0;
    dig_cnt   = '0;
    code_acc  = '0;
    code_err  = 1'b0;
    last_cr   = 1'b0;
    line_done = 1'b0;
    closed    = 1'b0;
  endfunction

  // advance the parser model by one transfer and return its output
  function automatic result_t parse_item(cmd_e op, logic [7:0] b);
    result_t r;
    logic    keep;
    logic    good;
    keep = 1'b0;
    case (op)
      CMD_START: clear_parse();
      CMD_CLOSE: begin
        if (!closed) begin
          closed    = 1'b1;
          line_done = 1'b1;
          if (sp_seen && dig_cnt == 2'd3 && !code_err) n_code_ok++;
          else n_code_err++;
        end
      end
      CMD_DATA: begin
        if (!closed && body_mode) begin
          if (body_cnt < BODY_LIMIT) begin
            body_cnt++;
            keep = 1'b1;
            n_kept++;
          end
        end else if (!closed) begin
          // bytes past the header limit only drive the separator match
          if (hdr_cnt < HEADER_LIMIT) begin
            hdr_cnt++;
            if (!line_done) begin
              if (last_cr && b == CH_LF) begin
                line_done = 1'b1;
              end else begin
                if (!sp_seen) begin
                  if (b == CH_SPACE) sp_seen = 1'b1;
                end else if (dig_cnt != 2'd3) begin
                  if (b >= CH_ZERO && b <= CH_NINE)
                    code_acc = CODE_W'(int'(code_acc) * 10 + int'(b - CH_ZERO));
                  else
                    code_err = 1'b1;
                  dig_cnt++;
                end
                last_cr = (b == CH_CR);
                if (hdr_cnt >= HEADER_LIMIT) begin
                  code_err  = 1'b1;
                  line_done = 1'b1;
                  n_hdr_full++;
                end
              end
            end
          end
          if (b == (sep_pos[0] ? CH_LF : CH_CR)) begin
            sep_pos++;
            if (sep_pos >= 3'd4) begin
              sep_pos   = '0;
              body_mode = 1'b1;
            end
          end else begin
            // a stray CR restarts the match at its first character
            sep_pos = (b == CH_CR) ? 3'd1 : 3'd0;
          end
        end
      end
      default: ;
    endcase
    good       = line_done && sp_seen && dig_cnt == 2'd3 && !code_err;
    r.body     = keep ? b : 8'd0;
    r.keep     = keep;
    r.settled  = line_done;
    r.ok       = good;
    r.code     = good ? code_acc : '0;
    r.finished = closed;
    return r;
  endfunction

  task automatic send_item(input cmd_e op, input logic [7:0] b, input bit fixed,
                           input result_t fixed_res);
    result_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= op;
    do @(posedge clk_i); while (!s_ready);
    pred = parse_item(op, b);
    expected_q.push_back(fixed ? fixed_res : pred);
    n_items++;
  endtask

  // data or control transfer, now and then preceded by an ignored code
  task automatic send(input cmd_e op, input logic [7:0] b);
    if ($urandom_range(0, 49) == 0)
      send_item(CMD_NOP, 8'($urandom_range(0, 255)), 1'b0, '0);
    send_item(op, b, 1'b0, '0);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(CMD_DATA, s[i]);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(33, 126));
  endfunction

  task automatic close_link();
    cmd_e op;
    send(CMD_CLOSE, 8'($urandom_range(0, 255)));
    // traffic after close must leave the result frozen
    repeat ($urandom_range(0, 3)) begin
      op = cmd_e'($urandom_range(0, 3));
      if (op == CMD_START) op = CMD_DATA;
      send(op, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic gen_response(input int idx);
    int n;
    if ($urandom_range(0, 9) != 0) send(CMD_START, 8'($urandom_range(0, 255)));
    if (idx % 6 == 3) begin
      // status line that can overrun the header limit
      n = $urandom_range(120, 140);
      repeat (n) send(CMD_DATA, printable());
    end else begin
      send_text("HTTP/1.1");
      if ($urandom_range(0, 9) != 0) send(CMD_DATA, CH_SPACE);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 3;
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) send(CMD_DATA, printable());
        else send(CMD_DATA, 8'(CH_ZERO + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1) != 0) send_text(" OK");
    end
    if ($urandom_range(0, 11) == 0) begin
      close_link();
      return;
    end
    send(CMD_DATA, CH_CR);
    send(CMD_DATA, CH_LF);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(3, 12)) send(CMD_DATA, printable());
      if ($urandom_range(0, 7) == 0) send(CMD_DATA, CH_CR);
      send(CMD_DATA, CH_CR);
      send(CMD_DATA, CH_LF);
    end
    if ($urandom_range(0, 7) != 0) begin
      send(CMD_DATA, CH_CR);
      send(CMD_DATA, CH_LF);
    end
    n = (idx % 5 == 2) ? $urandom_range(128, 140) : $urandom_range(0, 20);
    repeat (n) send(CMD_DATA, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0) close_link();
  endtask

  task automatic add_row(input cmd_e op, input logic [7:0] b, input bit fixed,
                         input result_t res);
    stim_row_t row;
    row.op    = op;
    row.b     = b;
    row.fixed = fixed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // hold off the sender until the pipeline is empty
  task automatic drain_wait();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  // output stall pattern, with two long hold-offs to back up the input side
  initial begin
    int cyc;
    int mode;
    int seg_left;
    cyc = 0;
    mode = 0;
    seg_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 300 || cyc == 700) begin
        m_ready <= 1'b0;
        repeat (70) @(posedge clk_i);
        cyc += 70;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(16, 64);
        end
        seg_left--;
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= cyc[0];
          2: m_ready <= ($urandom_range(0, 9) < 7);
          default: m_ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    result_t got;
    result_t want;
    if (rst_ni && m_valid && m_ready) begin
      got = m_data[21:0];
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: %h", got);
        fails++;
      end else begin
        want = expected_q.pop_front();
        if (got.body !== want.body) begin
          $error("body_byte: expected %0d, got %0d", want.body, got.body);
          fails++;
        end
        if (got.keep !== want.keep) begin
          $error("body_keep: expected %0b, got %0b", want.keep, got.keep);
          fails++;
        end
        if (got.settled !== want.settled) begin
          $error("status_settled: expected %0b, got %0b", want.settled, got.settled);
          fails++;
        end
        if (got.ok !== want.ok) begin
          $error("status_ok: expected %0b, got %0b", want.ok, got.ok);
          fails++;
        end
        if (got.code !== want.code) begin
          $error("status_code: expected %0d, got %0d", want.code, got.code);
          fails++;
        end
        if (got.finished !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, got.finished);
          fails++;
        end
      end
    end
  end

  initial begin
    result_t idle_res;
    result_t bad_close;
    int resp;
    idle_res  = '0;
    bad_close = '0;
    bad_close.settled  = 1'b1;
    bad_close.finished = 1'b1;
    clear_parse();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_row(CMD_START, 8'h00, 1'b1, idle_res);
    add_row(CMD_NOP,   8'hFF, 1'b1, idle_res);
    add_row(CMD_DATA,  "H",   1'b0, '0);
    add_row(CMD_DATA,  " ",   1'b0, '0);
    add_row(CMD_DATA,  "2",   1'b0, '0);
    add_row(CMD_DATA,  "0",   1'b0, '0);
    add_row(CMD_DATA,  "0",   1'b0, '0);
    add_row(CMD_DATA,  CH_CR, 1'b0, '0);
    add_row(CMD_DATA,  CH_LF, 1'b0, '0);
    add_row(CMD_DATA,  CH_CR, 1'b0, '0);
    add_row(CMD_DATA,  CH_LF, 1'b0, '0);
    add_row(CMD_DATA,  8'hFF, 1'b0, '0);
    add_row(CMD_DATA,  8'h00, 1'b0, '0);
    add_row(CMD_NOP,   8'h5A, 1'b0, '0);
    add_row(CMD_CLOSE, 8'h00, 1'b0, '0);
    add_row(CMD_DATA,  8'hA5, 1'b0, '0);
    add_row(CMD_CLOSE, 8'h00, 1'b0, '0);
    add_row(CMD_START, 8'h00, 1'b1, idle_res);
    add_row(CMD_DATA,  "X",   1'b0, '0);
    add_row(CMD_DATA,  " ",   1'b0, '0);
    add_row(CMD_DATA,  "2",   1'b0, '0);
    add_row(CMD_DATA,  "a",   1'b0, '0);
    add_row(CMD_CLOSE, 8'h00, 1'b1, bad_close);
    add_row(CMD_START, 8'hFF, 1'b1, idle_res);
    add_row(CMD_CLOSE, 8'h00, 1'b1, bad_close);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].res);
    drain_wait();

    resp = 0;
    while (n_items < NUM_ITEMS) begin
      gen_response(resp);
      resp++;
    end
    s_valid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (8) @(posedge clk_i);

    $display("Run: %0d input transfers, %0d results checked, %0d responses.",
             n_items, n_results, resp);
    $display("Kept %0d body bytes; closes with good code %0d, bad code %0d; %0d header overruns.",
             n_kept, n_code_ok, n_code_err, n_hdr_full);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
